// ===== design/bbt_pkg.sv =====
// ---------------------------------------------------------------------------
// bbt_pkg: shared types and constants
// Trit codes, character codes, microcode word layout and the control program
// for the binary to balanced ternary text converter.
// ---------------------------------------------------------------------------
`default_nettype none

package bbt_pkg;

    typedef logic [1:0] trit_t;

    localparam trit_t TRIT_ZERO  = 2'd0;
    localparam trit_t TRIT_PLUS  = 2'd1;
    localparam trit_t TRIT_MINUS = 2'd2;

    typedef logic [6:0] char_t;

    localparam char_t CH_MINUS = 7'd84;
    localparam char_t CH_ZERO  = 7'd48;
    localparam char_t CH_PLUS  = 7'd49;

    localparam int          MAXC_W     = 6;
    localparam logic [5:0]  MAXC_RESET = 6'd63;

    // multiplicative inverse of 3 modulo 2^32, exact division by 3
    localparam logic [31:0] INV3 = 32'hAAAA_AAAB;

    typedef logic [2:0] step_t;

    localparam step_t STEP_IDLE = 3'd0;
    localparam step_t STEP_CHK  = 3'd1;
    localparam step_t STEP_REM  = 3'd2;
    localparam step_t STEP_DIV  = 3'd3;
    localparam step_t STEP_ESET = 3'd4;
    localparam step_t STEP_EMIT = 3'd5;
    localparam step_t STEP_FIN  = 3'd6;

    typedef enum logic [2:0] {
        ACT_NOP,
        ACT_LOAD,
        ACT_REM,
        ACT_DIV,
        ACT_ESET,
        ACT_EMIT
    } act_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_DONE,
        COND_MAXC_ZERO,
        COND_EMIT_MORE
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t target;
    } ctl_word_t;

    typedef struct packed {
        logic in_fire;
        logic done;
        logic maxc_zero;
        logic emit_final;
    } status_t;

    // control program: jump to target when cond holds, else fall through
    function automatic ctl_word_t ucode_rom(input step_t s);
        ctl_word_t w;
        case (s)
            STEP_IDLE: w = '{act: ACT_LOAD, cond: COND_NO_INPUT,  target: STEP_IDLE};
            STEP_CHK:  w = '{act: ACT_NOP,  cond: COND_DONE,      target: STEP_ESET};
            STEP_REM:  w = '{act: ACT_REM,  cond: COND_NEVER,     target: STEP_IDLE};
            STEP_DIV:  w = '{act: ACT_DIV,  cond: COND_ALWAYS,    target: STEP_CHK};
            STEP_ESET: w = '{act: ACT_ESET, cond: COND_MAXC_ZERO, target: STEP_IDLE};
            STEP_EMIT: w = '{act: ACT_EMIT, cond: COND_EMIT_MORE, target: STEP_EMIT};
            STEP_FIN:  w = '{act: ACT_NOP,  cond: COND_ALWAYS,    target: STEP_IDLE};
            default:   w = '{act: ACT_NOP,  cond: COND_ALWAYS,    target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== design/bbt_channels_if.sv =====
// ---------------------------------------------------------------------------
// bbt channels: request interfaces
// Input channel carries one signed value, output channel one character.
// ---------------------------------------------------------------------------
`default_nettype none

interface bbt_num_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface bbt_text_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_code;
    logic       last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

`default_nettype wire

// ===== design/bbt_sequencer.sv =====
// ---------------------------------------------------------------------------
// bbt_sequencer: microcode step counter
// Reads the control word for the current step and picks the next step from
// the word's condition and the datapath status.
// ---------------------------------------------------------------------------
`default_nettype none

module bbt_sequencer (
    input  wire                  clk,
    input  wire                  rst_n,
    input  bbt_pkg::status_t     stat,
    output bbt_pkg::ctl_word_t   ctl
);

    bbt_pkg::step_t step_reg;
    bbt_pkg::step_t step_next;
    logic           take_jump;

    assign ctl = bbt_pkg::ucode_rom(step_reg);

    always_comb
    begin
        case (ctl.cond)
            bbt_pkg::COND_NEVER:     take_jump = 1'b0;
            bbt_pkg::COND_ALWAYS:    take_jump = 1'b1;
            bbt_pkg::COND_NO_INPUT:  take_jump = !stat.in_fire;
            bbt_pkg::COND_DONE:      take_jump = stat.done;
            bbt_pkg::COND_MAXC_ZERO: take_jump = stat.maxc_zero;
            bbt_pkg::COND_EMIT_MORE: take_jump = !stat.emit_final;
            default:                 take_jump = 1'b1;
        endcase
    end

    always_comb
    begin
        step_next = take_jump ? ctl.target : bbt_pkg::step_t'(step_reg + 3'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= bbt_pkg::STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/bbt_datapath.sv =====
// ---------------------------------------------------------------------------
// bbt_datapath: magnitude divider, trit store and character output
// Works on the magnitude of the value; the sign swaps plus and minus trits.
// ---------------------------------------------------------------------------
`default_nettype none

module bbt_datapath #(
    parameter int MAX_TRITS = 21
) (
    input  wire                  clk,
    input  wire                  rst_n,
    bbt_num_if.sink              num,
    bbt_text_if.source           text,
    input  wire                  cfg_we,
    input  wire [5:0]            cfg_wdata,
    input  bbt_pkg::ctl_word_t   ctl,
    output bbt_pkg::status_t     stat
);

    localparam int CNT_W = $clog2(MAX_TRITS + 1);
    localparam int IDX_W = $clog2(MAX_TRITS);
    localparam int CMP_W = (CNT_W > bbt_pkg::MAXC_W) ? CNT_W : bbt_pkg::MAXC_W;

    logic [31:0]        mag_reg;
    logic               neg_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   pos_reg;
    logic [CNT_W-1:0]   left_reg;
    logic [5:0]         max_chars_reg;
    logic               out_valid_reg;
    bbt_pkg::char_t     out_char_reg;
    logic               out_last_reg;

    bbt_pkg::trit_t     trit_store [MAX_TRITS];

    logic [5:0]         chunk_sum;
    logic [3:0]         fold_sum;
    logic [1:0]         rem3;
    bbt_pkg::trit_t     mag_trit;
    bbt_pkg::trit_t     signed_trit;
    logic [31:0]        mag_adj;
    logic [31:0]        product;
    logic [CNT_W-1:0]   emit_len;
    logic               slot_free;
    logic               in_fire;
    bbt_pkg::trit_t     rd_trit;
    bbt_pkg::char_t     rd_char;

    assign num.ready   = (ctl.act == bbt_pkg::ACT_LOAD);
    assign in_fire     = num.valid && num.ready;
    assign slot_free   = !out_valid_reg || text.ready;

    assign text.valid     = out_valid_reg;
    assign text.char_code = out_char_reg;
    assign text.last      = out_last_reg;

    // x mod 3: base-4 digits each weigh 1 mod 3
    always_comb
    begin
        chunk_sum = '0;
        for (int k = 0; k < 16; k++)
        begin
            chunk_sum = chunk_sum + 6'(mag_reg[2*k +: 2]);
        end
        fold_sum = 4'(chunk_sum[1:0]) + 4'(chunk_sum[3:2]) + 4'(chunk_sum[5:4]);
        case (fold_sum)
            4'd0, 4'd3, 4'd6, 4'd9: rem3 = 2'd0;
            4'd1, 4'd4, 4'd7:       rem3 = 2'd1;
            default:                rem3 = 2'd2;
        endcase
    end

    always_comb
    begin
        case (rem3)
            2'd1:
            begin
                mag_trit = bbt_pkg::TRIT_PLUS;
                mag_adj  = mag_reg - 32'd1;
            end
            2'd2:
            begin
                mag_trit = bbt_pkg::TRIT_MINUS;
                mag_adj  = mag_reg + 32'd1;
            end
            default:
            begin
                mag_trit = bbt_pkg::TRIT_ZERO;
                mag_adj  = mag_reg;
            end
        endcase
        if (neg_reg && mag_trit == bbt_pkg::TRIT_PLUS)
            signed_trit = bbt_pkg::TRIT_MINUS;
        else if (neg_reg && mag_trit == bbt_pkg::TRIT_MINUS)
            signed_trit = bbt_pkg::TRIT_PLUS;
        else
            signed_trit = mag_trit;
    end

    // low word of the product is the exact quotient of a multiple of 3
    assign product = mag_reg * bbt_pkg::INV3;

    always_comb
    begin
        if (CMP_W'(count_reg) < CMP_W'(max_chars_reg))
            emit_len = count_reg;
        else
            emit_len = CNT_W'(max_chars_reg);
    end

    always_comb
    begin
        rd_trit = trit_store[pos_reg];
        case (rd_trit)
            bbt_pkg::TRIT_PLUS:  rd_char = bbt_pkg::CH_PLUS;
            bbt_pkg::TRIT_MINUS: rd_char = bbt_pkg::CH_MINUS;
            default:             rd_char = bbt_pkg::CH_ZERO;
        endcase
    end

    always_comb
    begin
        stat.in_fire    = in_fire;
        stat.done       = (mag_reg == 32'd0 && count_reg != '0)
                          || count_reg == CNT_W'(MAX_TRITS);
        stat.maxc_zero  = (max_chars_reg == 6'd0);
        stat.emit_final = slot_free && left_reg == CNT_W'(1);
    end

    // magnitude register has no reset; it is loaded with every request
    always_ff @(posedge clk)
    begin
        case (ctl.act)
            bbt_pkg::ACT_LOAD:
            begin
                if (in_fire)
                    mag_reg <= num.value[31] ? (32'd0 - num.value) : num.value;
            end
            bbt_pkg::ACT_REM: mag_reg <= mag_adj;
            bbt_pkg::ACT_DIV: mag_reg <= product;
            default:          mag_reg <= mag_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.act == bbt_pkg::ACT_REM)
            trit_store[count_reg[IDX_W-1:0]] <= signed_trit;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.act == bbt_pkg::ACT_EMIT && slot_free)
        begin
            out_char_reg <= rd_char;
            out_last_reg <= (left_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neg_reg       <= 1'b0;
            count_reg     <= '0;
            pos_reg       <= '0;
            left_reg      <= '0;
            max_chars_reg <= bbt_pkg::MAXC_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                max_chars_reg <= cfg_wdata;

            case (ctl.act)
                bbt_pkg::ACT_LOAD:
                begin
                    if (in_fire)
                    begin
                        neg_reg   <= num.value[31];
                        count_reg <= '0;
                    end
                end
                bbt_pkg::ACT_REM:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                bbt_pkg::ACT_ESET:
                begin
                    left_reg <= emit_len;
                    pos_reg  <= IDX_W'(count_reg - CNT_W'(1));
                end
                bbt_pkg::ACT_EMIT:
                begin
                    if (slot_free)
                    begin
                        left_reg <= left_reg - CNT_W'(1);
                        pos_reg  <= pos_reg - IDX_W'(1);
                    end
                end
                default:
                begin
                end
            endcase

            if (ctl.act == bbt_pkg::ACT_EMIT && slot_free)
                out_valid_reg <= 1'b1;
            else if (text.ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== design/binary_to_balanced_ternary_text.sv =====
// ---------------------------------------------------------------------------
// binary_to_balanced_ternary_text: signed integer to balanced ternary text
// Converts one signed 32-bit value per request into ASCII trits 'T' '0' '1'.
// ---------------------------------------------------------------------------
// Usage:
//   num  : input requests, one signed 32-bit value each.
//   text : output requests, one ASCII character each, most significant trit
//          first; last marks the final character of a value.
//   cfg_we / cfg_wdata : write max_chars (reset 63); write only while idle.
//          Zero emits nothing; fewer than the digit count drops the low trits.
// Sequence: a value with D trits is accepted in the idle step, then passes
//   once per trit through the microcode divide loop (check, remainder,
//   multiply by the inverse of 3), then the emit setup step, one character
//   per cycle while the receiver does not stall, and a final step. D is at
//   most 21. One value is in work at a time; num.ready is high only in the
//   idle step.
// Reset clears the sequencer and the output valid flag; the block then waits
// for a request. A stalled receiver holds the current character in the
// output register and the sequencer waits in its emit step.
// ---------------------------------------------------------------------------
`default_nettype none

module binary_to_balanced_ternary_text #(
    parameter int MAX_TRITS = 21
) (
    input  wire          clk,
    input  wire          rst_n,
    bbt_num_if.sink      num,
    bbt_text_if.source   text,
    input  wire          cfg_we,
    input  wire [5:0]    cfg_wdata
);

    bbt_pkg::ctl_word_t ctl;
    bbt_pkg::status_t   stat;

    bbt_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    bbt_datapath #(
        .MAX_TRITS (MAX_TRITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .num       (num),
        .text      (text),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .ctl       (ctl),
        .stat      (stat)
    );

endmodule

`default_nettype wire
